[rtl/phcv_pkg.sv]
// Package: constants, status codes and the FNV prime multiply for the packet checksum verifier.
package phcv_pkg;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned M_DATA_W = 104;

    localparam logic [WORD_W-1:0] MAGIC_VALUE  = 32'h4748_5354;
    localparam logic [WORD_W-1:0] HASH_PRIME   = 32'h0100_0193;
    localparam logic [WORD_W-1:0] FNV_BASIS    = 32'h811c_9dc5;
    localparam logic [DATA_W-1:0] ZEROED_BYTE  = 8'h00;
    localparam logic [LEN_W-1:0]  HEADER_BYTES = 16'd16;
    localparam logic [LEN_W-1:0]  POS_MAX      = 16'hFFFF;
    localparam logic [LEN_W-1:0]  MAX_RESET    = 16'd4096;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_TOO_LONG  = 3'd2,
        ST_MISMATCH  = 3'd3,
        ST_TOO_SHORT = 3'd4
    } status_t;

    // Multiply by the FNV prime 0x01000193 as a sum of shifted copies.
    function automatic logic [WORD_W-1:0] fnv_mul(input logic [WORD_W-1:0] x);
        fnv_mul = x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
    endfunction

endpackage

[rtl/packet_header_checksum_verifier_core.sv]
// Top level: byte-stream FNV-1a checksum and header verifier with one verdict per packet.
// Verdict path: the accepted last byte passes the input register, then the result register.
// Throughput: one byte request per cycle bar verdict stalls; the FNV step (xor and a constant
//   multiply as shifts and adds) finishes between the input register and the state.
// A packet verdict waits in the result register while further bytes keep flowing.
// Reset: aresetn is synchronous, active low; it clears the pipeline and packet state
//   and sets the length limit to 4096 bytes.
module packet_header_checksum_verifier_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration: largest accepted packet length in bytes
    input  logic                           cfg_we,
    input  logic [phcv_pkg::LEN_W-1:0]     cfg_wdata,
    // byte stream in
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [phcv_pkg::DATA_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,   // last_byte
    // verdict out
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [phcv_pkg::M_DATA_W-1:0]  m_tdata    // [2:0] status, [34:3] seq_id,
                                                      // [66:35] batch_cnt,
                                                      // [98:67] computed_hash, rest zero
);
    import phcv_pkg::*;

    // Configuration
    logic [LEN_W-1:0]  max_bytes_reg;

    // Input register
    logic              in_valid_reg;
    logic [DATA_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // Packet state
    logic [WORD_W-1:0] hash_reg,   hash_next;
    logic [LEN_W-1:0]  pos_reg,    pos_next;
    logic [WORD_W-1:0] magic_reg,  magic_next;
    logic [WORD_W-1:0] chk_reg,    chk_next;
    logic [WORD_W-1:0] seq_reg,    seq_next;
    logic [WORD_W-1:0] cnt_reg,    cnt_next;
    logic              over_reg,   over_next;

    // Result register
    logic              m_valid_reg;
    status_t           status_reg, status_next;
    logic [WORD_W-1:0] seq_out_reg, seq_out_next;
    logic [WORD_W-1:0] cnt_out_reg, cnt_out_next;
    logic [WORD_W-1:0] hash_out_reg;

    logic              in_consume;
    logic              out_load;

    // A byte leaves the input register unless it closes a packet and the verdict slot is full.
    assign out_load   = in_consume && in_last_reg;
    assign in_consume = in_valid_reg && (!in_last_reg || !m_valid_reg || m_tready);
    assign s_tready   = !in_valid_reg || in_consume;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, hash_out_reg, cnt_out_reg, seq_out_reg, status_reg};

    // Header capture, hash step, length check and verdict for the byte in the input register.
    always_comb begin
        logic [LEN_W:0]    count;
        logic              saturated;
        logic              in_header;
        logic [4:0]        sh;
        logic [WORD_W-1:0] lane_mask;
        logic [WORD_W-1:0] lane_val;
        logic [DATA_W-1:0] hash_byte;

        count     = {1'b0, pos_reg} + {{LEN_W{1'b0}}, 1'b1};
        saturated = (pos_reg == POS_MAX);
        in_header = (pos_reg[LEN_W-1:4] == '0);
        sh        = {pos_reg[1:0], 3'b000};
        lane_mask = ~({{(WORD_W-DATA_W){1'b0}}, 8'hFF} << sh);
        lane_val  = {{(WORD_W-DATA_W){1'b0}}, in_byte_reg} << sh;

        magic_next = magic_reg;
        chk_next   = chk_reg;
        seq_next   = seq_reg;
        cnt_next   = cnt_reg;
        if (in_header) begin
            unique case (pos_reg[3:2])
                2'd0:    magic_next = (magic_reg & lane_mask) | lane_val;
                2'd1:    chk_next   = (chk_reg   & lane_mask) | lane_val;
                2'd2:    seq_next   = (seq_reg   & lane_mask) | lane_val;
                default: cnt_next   = (cnt_reg   & lane_mask) | lane_val;
            endcase
        end

        // checksum bytes enter the hash as zero
        hash_byte = (in_header && pos_reg[3:2] == 2'd1) ? ZEROED_BYTE : in_byte_reg;
        hash_next = fnv_mul(hash_reg ^ {{(WORD_W-DATA_W){1'b0}}, hash_byte});

        over_next = over_reg || saturated || (count > {1'b0, max_bytes_reg});
        pos_next  = saturated ? POS_MAX : count[LEN_W-1:0];

        priority if (count < {1'b0, HEADER_BYTES}) begin
            status_next = ST_TOO_SHORT;
        end else if (magic_next != MAGIC_VALUE) begin
            status_next = ST_BAD_MAGIC;
        end else if (over_next) begin
            status_next = ST_TOO_LONG;
        end else if (hash_next != chk_next) begin
            status_next = ST_MISMATCH;
        end else begin
            status_next = ST_OK;
        end

        seq_out_next = (status_next == ST_TOO_SHORT) ? '0 : seq_next;
        cnt_out_next = (status_next == ST_TOO_SHORT) ? '0 : cnt_next;
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= MAX_RESET;
        end else if (cfg_we) begin
            max_bytes_reg <= cfg_wdata;
        end
    end

    // Input register: hold the byte until the processing stage takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Packet state: advance on each byte, drop back to the start after the last one.
    always_ff @(posedge aclk) begin
        if (!aresetn || out_load) begin
            hash_reg  <= FNV_BASIS;
            pos_reg   <= '0;
            magic_reg <= '0;
            chk_reg   <= '0;
            seq_reg   <= '0;
            cnt_reg   <= '0;
            over_reg  <= 1'b0;
        end else if (in_consume) begin
            hash_reg  <= hash_next;
            pos_reg   <= pos_next;
            magic_reg <= magic_next;
            chk_reg   <= chk_next;
            seq_reg   <= seq_next;
            cnt_reg   <= cnt_next;
            over_reg  <= over_next;
        end
    end

    // Result register: load a verdict, hold it until taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            status_reg   <= status_next;
            seq_out_reg  <= seq_out_next;
            cnt_out_reg  <= cnt_out_next;
            hash_out_reg <= hash_next;
        end
    end

`ifndef SYNTHESIS
    // A closing byte always leaves the packet state at the start of a new packet.
    a_restart_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (pos_reg == '0) && (hash_reg == FNV_BASIS) && !over_reg)
        else $error("packet state not cleared after last byte");

    // Each mid-packet byte moves the position on by exactly one until it saturates.
    a_pos_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_consume && !in_last_reg && pos_reg != POS_MAX)
            |=> pos_reg == $past(pos_reg) + 16'd1)
        else $error("byte position did not advance by one");

    // A short-packet verdict carries no header words.
    a_short_clears_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg == ST_TOO_SHORT) |-> (seq_out_reg == '0 && cnt_out_reg == '0))
        else $error("short packet reports header fields");

    // A waiting verdict is never overwritten by the next packet.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !out_load)
        else $error("verdict overwritten while waiting");
`endif

endmodule

[sim/phcv_verdict_checker.sv]
// Checker: watches both streams, predicts each packet verdict and compares it.
module phcv_verdict_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [phcv_pkg::LEN_W-1:0]    cfg_wdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [phcv_pkg::DATA_W-1:0]   s_tdata,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [phcv_pkg::M_DATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import phcv_pkg::*;

    typedef struct {
        status_t           status;
        logic [WORD_W-1:0] seq_id;
        logic [WORD_W-1:0] batch;
        logic [WORD_W-1:0] hash;
    } verdict_t;

    verdict_t verdicts_due[$];

    // Shadow of the packet state and the length limit
    logic [WORD_W-1:0] hash_acc;
    logic [WORD_W-1:0] magic_acc;
    logic [WORD_W-1:0] sum_acc;
    logic [WORD_W-1:0] seq_acc;
    logic [WORD_W-1:0] batch_acc;
    int unsigned       byte_pos;
    logic              long_seen;
    logic [LEN_W-1:0]  limit;

    int mismatches = 0;
    int due        = 0;

    assign fail_count    = mismatches;
    assign pending_count = due;

    // Working variables for one clock edge
    verdict_t          seen;
    verdict_t          want;
    logic [DATA_W-1:0] folded;
    int unsigned       total;
    logic              saturated;

    task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
                               input logic [WORD_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, actual %h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    function automatic void clear_packet();
        hash_acc  = FNV_BASIS;
        magic_acc = '0;
        sum_acc   = '0;
        seq_acc   = '0;
        batch_acc = '0;
        byte_pos  = 0;
        long_seen = 1'b0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_packet();
            limit = MAX_RESET;
            verdicts_due.delete();
            due = 0;
        end else begin
            if (cfg_we)
                limit = cfg_wdata;

            // compare a delivered verdict with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (verdicts_due.size() == 0) begin
                    $error("unexpected verdict %h with nothing predicted", m_tdata);
                    mismatches++;
                end else begin
                    want = verdicts_due.pop_front();
                    check_field("status", 32'(want.status), 32'(m_tdata[2:0]));
                    check_field("seq_id", want.seq_id, m_tdata[34:3]);
                    check_field("batch_cnt", want.batch, m_tdata[66:35]);
                    check_field("computed_hash", want.hash, m_tdata[98:67]);
                    check_field("padding", '0, 32'(m_tdata[M_DATA_W-1:99]));
                end
            end

            // fold an accepted byte into the packet state
            if (s_tvalid && s_tready) begin
                saturated = (byte_pos >= 32'(POS_MAX));
                if (byte_pos < 4)
                    magic_acc[8*(byte_pos%4) +: 8] = s_tdata;
                else if (byte_pos < 8)
                    sum_acc[8*(byte_pos%4) +: 8] = s_tdata;
                else if (byte_pos < 12)
                    seq_acc[8*(byte_pos%4) +: 8] = s_tdata;
                else if (byte_pos < 32'(HEADER_BYTES))
                    batch_acc[8*(byte_pos%4) +: 8] = s_tdata;

                // checksum bytes enter the hash as zero
                folded   = (byte_pos >= 4 && byte_pos < 8) ? ZEROED_BYTE : s_tdata;
                hash_acc = (hash_acc ^ {24'd0, folded}) * HASH_PRIME;

                total = byte_pos + 1;
                if (saturated || total > 32'(limit))
                    long_seen = 1'b1;
                byte_pos = saturated ? 32'(POS_MAX) : total;

                if (s_tlast) begin
                    if (total < 32'(HEADER_BYTES))
                        seen.status = ST_TOO_SHORT;
                    else if (magic_acc != MAGIC_VALUE)
                        seen.status = ST_BAD_MAGIC;
                    else if (long_seen)
                        seen.status = ST_TOO_LONG;
                    else if (hash_acc != sum_acc)
                        seen.status = ST_MISMATCH;
                    else
                        seen.status = ST_OK;
                    seen.seq_id = (seen.status == ST_TOO_SHORT) ? '0 : seq_acc;
                    seen.batch  = (seen.status == ST_TOO_SHORT) ? '0 : batch_acc;
                    seen.hash   = hash_acc;
                    verdicts_due.push_back(seen);
                    clear_packet();
                end
            end
            due = verdicts_due.size();
        end
    end

endmodule

[sim/testbench.sv]
// Testbench top: drives byte packets and limit writes into the checksum verifier.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import phcv_pkg::*;

    // Generous ceiling on the run length, even under stalls.
    localparam int CYCLE_LIMIT = 100_000;

    typedef enum {PK_GOOD, PK_BAD_MAGIC, PK_BAD_SUM, PK_NOISE} pkt_kind_t;
    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [LEN_W-1:0]    cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    int fail_count;
    int pending_count;
    int cycle_count = 0;

    // Idle and stall rates in percent, changed per phase
    int idle_pct  = 0;
    int stall_pct = 0;

    packet_header_checksum_verifier_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    phcv_verdict_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run: no verdict ever comes once the limit is passed.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stall the verdict side at the phase's rate; a zero rate keeps it always ready.
    always @(negedge aclk)
        m_tready = ($urandom_range(99) >= stall_pct);

    // FNV-1a over a whole packet with the checksum bytes taken as zero; used to build
    // packets that carry a correct checksum.
    function automatic logic [WORD_W-1:0] packet_fnv(input logic [DATA_W-1:0] pkt[]);
        logic [WORD_W-1:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < pkt.size(); i++)
            h = (h ^ ((i >= 4 && i < 8) ? 32'd0 : {24'd0, pkt[i]})) * HASH_PRIME;
        return h;
    endfunction

    // Offer one byte request; entered and left at a falling edge. Valid is left high
    // after acceptance so that back-to-back requests never drop it within a step.
    task automatic push_byte(input logic [DATA_W-1:0] b, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Hold the sender until every predicted verdict has been delivered, then let the
    // last accepted byte clear the two-stage pipeline.
    task automatic settle();
        s_tvalid = 1'b0;
        while (pending_count != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [LEN_W-1:0] v);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    // Build and send one packet. A split position >= 0 pauses the packet there, waits
    // for the block to go quiet and writes a new length limit before the rest goes.
    task automatic send_packet(input int len, input pkt_kind_t kind, input fill_t fill,
                               input int split_at, input logic [LEN_W-1:0] split_limit);
        logic [DATA_W-1:0] pkt[];
        logic [WORD_W-1:0] sum;
        pkt = new[len];
        for (int i = 0; i < len; i++)
            pkt[i] = (fill == FILL_RANDOM) ? DATA_W'($urandom) :
                     (fill == FILL_ZERO)   ? 8'h00 : 8'hFF;
        if (kind != PK_NOISE)
            for (int i = 0; i < 4 && i < len; i++)
                pkt[i] = MAGIC_VALUE[8*i +: 8];
        // flip one magic bit so the word is certain to differ
        if (kind == PK_BAD_MAGIC && len >= 4)
            pkt[$urandom_range(3)] ^= DATA_W'(1 << $urandom_range(7));
        sum = packet_fnv(pkt);
        if (kind == PK_BAD_SUM)
            sum ^= WORD_W'(1) << $urandom_range(31);
        if (kind != PK_NOISE)
            for (int i = 4; i < 8 && i < len; i++)
                pkt[i] = sum[8*(i-4) +: 8];
        for (int i = 0; i < len; i++) begin
            if (i == split_at) begin
                settle();
                write_limit(split_limit);
            end
            push_byte(pkt[i], i == len - 1);
        end
    endtask

    int        phase_bytes;
    int        len;
    int        roll;
    pkt_kind_t kind;

    // Idle and stall pairs, and the limit used in each random phase
    int               idle_tab[8]  = '{0, 47, 0, 33, 0, 47, 0, 33};
    int               stall_tab[8] = '{0, 0, 47, 33, 0, 0, 47, 33};
    logic [LEN_W-1:0] limit_tab[8] = '{16'd4096, 16'd16, 16'd65535, 16'd24,
                                       16'd20, 16'd32, 16'd65535, 16'd16};

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: reset limit first, then the header extremes and every status
        send_packet(16, PK_GOOD, FILL_ONES, -1, '0);
        send_packet(20, PK_GOOD, FILL_ZERO, -1, '0);
        send_packet(16, PK_BAD_MAGIC, FILL_RANDOM, -1, '0);
        send_packet(17, PK_BAD_SUM, FILL_RANDOM, -1, '0);
        // short packets: a lone last byte, and one byte under a full header
        send_packet(1, PK_GOOD, FILL_RANDOM, -1, '0);
        send_packet(15, PK_GOOD, FILL_ONES, -1, '0);
        // smallest limit: one byte over is too long, exactly at the limit is fine
        settle();
        write_limit(16'd16);
        send_packet(17, PK_GOOD, FILL_RANDOM, -1, '0);
        send_packet(16, PK_GOOD, FILL_RANDOM, -1, '0);
        // limit raised mid-packet before the count passes it: no length error
        send_packet(24, PK_GOOD, FILL_RANDOM, 8, 16'd65535);
        // limit lowered mid-packet: later bytes exceed it
        send_packet(24, PK_GOOD, FILL_RANDOM, 20, 16'd16);
        // overrun already seen stays sticky after the limit is raised again
        send_packet(24, PK_GOOD, FILL_RANDOM, 20, 16'd65535);

        // Random phases: mostly well-formed packets with random payload
        for (int p = 0; p < 8; p++) begin
            settle();
            idle_pct  = idle_tab[p];
            stall_pct = stall_tab[p];
            write_limit((p == 4) ? LEN_W'($urandom_range(17, 65535)) : limit_tab[p]);
            phase_bytes = 0;
            while (phase_bytes < 24) begin
                roll = $urandom_range(99);
                len  = (roll < 85) ? $urandom_range(16, 32) :
                       (roll < 95) ? $urandom_range(1, 15) : $urandom_range(33, 64);
                roll = $urandom_range(99);
                kind = (roll < 60) ? PK_GOOD :
                       (roll < 75) ? PK_BAD_SUM :
                       (roll < 85) ? PK_BAD_MAGIC : PK_NOISE;
                send_packet(len, kind, FILL_RANDOM, -1, '0);
                phase_bytes += len;
            end
        end

        // Drain: wait for every verdict, then idle to catch any stray output
        settle();
        repeat (8) @(negedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
